// File: design/multi_stack_shared_buffer_defines.svh
// Assertion macros used by the checker file.
`ifndef MULTI_STACK_SHARED_BUFFER_DEFINES_SVH
`define MULTI_STACK_SHARED_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MSSB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MSSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mssb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mssb_pkg;

	localparam int NUM_STACKS_DEF = 8;
	localparam int CAPACITY_DEF   = 64;

	localparam int SID_IN_W = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PUSH_WR,
		S_POP_SLOT,
		S_POP_WR
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic    capture;
		logic    rd_slot;
		logic    wr_push;
		logic    wr_pop;
		logic    load_out;
		status_t out_code;
	} mssb_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic sid_ok;
		logic free_null;
		logic head_null;
		logic out_free;
	} mssb_sts_t;

endpackage

`default_nettype wire

// File: design/mssb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mssb_ctrl import mssb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      cmd,
	input  wire mssb_sts_t sts,
	output logic           in_stall,
	output mssb_cmd_t      ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		ctl          = '0;
		ctl.out_code = ST_DONE;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = (cmd == CMD_POP) ? S_POP_SLOT : S_PUSH_WR;
				end
			end
			S_PUSH_WR: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					if (sts.sid_ok && !sts.free_null) begin
						ctl.wr_push  = 1'b1;
						ctl.out_code = ST_DONE;
					end else begin
						ctl.out_code = ST_FULL;
					end
					state_d = S_IDLE;
				end
			end
			S_POP_SLOT: begin
				if (!sts.sid_ok || sts.head_null) begin
					// refuse: nothing to unlink
					if (sts.out_free) begin
						ctl.load_out = 1'b1;
						ctl.out_code = ST_EMPTY;
						state_d      = S_IDLE;
					end
				end else begin
					ctl.rd_slot = 1'b1;
					state_d     = S_POP_WR;
				end
			end
			S_POP_WR: begin
				if (sts.out_free) begin
					ctl.wr_pop   = 1'b1;
					ctl.load_out = 1'b1;
					ctl.out_code = ST_DONE;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/mssb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mssb_datapath import mssb_pkg::*; #(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int CAPACITY   = CAPACITY_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [SID_IN_W-1:0]        stack_id,
	input  wire logic signed [VALUE_W-1:0]  push_value,
	input  wire logic                       out_stall,
	input  wire mssb_cmd_t                  ctl,
	output mssb_sts_t                       sts,
	output logic                            out_valid,
	output logic [STATUS_W-1:0]             status,
	output logic signed [VALUE_W-1:0]       pop_value
);

	localparam int LINK_W = $clog2(CAPACITY + 1);
	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int SCMP_W = SID_IN_W + SID_W;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

	// Stores
	logic [LINK_W-1:0]         head_mem [NUM_STACKS];
	logic [NUM_STACKS-1:0]     head_vld_q;
	logic [LINK_W-1:0]         link_mem [CAPACITY];
	logic signed [VALUE_W-1:0] data_mem [CAPACITY];

	// Captured item
	logic signed [VALUE_W-1:0] val_q;
	logic [SID_W-1:0]          sid_q;
	logic                      sid_ok_q;

	// Free list and fill count (slots at or above hwm were never taken)
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] hwm_q;

	// Registered reads
	logic [LINK_W-1:0]         head_rd_q;
	logic                      head_vld_rd_q;
	logic [LINK_W-1:0]         link_rd_q;
	logic                      link_fresh_q;
	logic [LINK_W-1:0]         link_seq_q;
	logic signed [VALUE_W-1:0] data_rd_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic signed [VALUE_W-1:0] out_pop_q;

	logic [SCMP_W-1:0] sid_in_wide;
	logic [SID_W-1:0]  sid_in_idx;
	logic [LINK_W-1:0] head_cur;
	logic [LINK_W-1:0] link_cur;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] head_slot;
	logic [SLOT_W-1:0] link_rd_addr;
	logic [SLOT_W-1:0] link_wr_addr;
	logic [LINK_W-1:0] link_wr_data;
	logic [LINK_W-1:0] head_wr_data;

	assign sid_in_wide = SCMP_W'(stack_id);
	assign sid_in_idx  = sid_in_wide[SID_W-1:0];

	assign head_cur  = head_vld_rd_q ? head_rd_q : NULL_LINK;
	assign link_cur  = link_fresh_q ? link_seq_q : link_rd_q;
	assign free_slot = free_head_q[SLOT_W-1:0];
	assign head_slot = head_cur[SLOT_W-1:0];

	assign link_rd_addr = ctl.rd_slot ? head_slot : free_slot;
	assign link_wr_addr = ctl.wr_pop ? head_slot : free_slot;
	assign link_wr_data = ctl.wr_pop ? free_head_q : head_cur;
	assign head_wr_data = ctl.wr_pop ? link_cur : free_head_q;

	assign sts.sid_ok    = sid_ok_q;
	assign sts.free_null = (free_head_q >= NULL_LINK);
	assign sts.head_null = (head_cur >= NULL_LINK);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Capture the item
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			val_q    <= push_value;
			sid_q    <= sid_in_idx;
			sid_ok_q <= (sid_in_wide < SCMP_W'(NUM_STACKS));
		end
	end

	// Head store
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			head_rd_q <= head_mem[sid_in_idx];
		end
		if (ctl.wr_push || ctl.wr_pop) begin
			head_mem[sid_q] <= head_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q    <= '0;
			head_vld_rd_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				head_vld_rd_q <= head_vld_q[sid_in_idx];
			end
			if (ctl.wr_push || ctl.wr_pop) begin
				head_vld_q[sid_q] <= 1'b1;
			end
		end
	end

	// Link store
	always_ff @(posedge clk) begin
		if (ctl.capture || ctl.rd_slot) begin
			link_rd_q <= link_mem[link_rd_addr];
		end
		if (ctl.wr_push || ctl.wr_pop) begin
			link_mem[link_wr_addr] <= link_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			link_fresh_q <= !(free_head_q < hwm_q);
			link_seq_q   <= free_head_q + LINK_W'(1);
		end else if (ctl.rd_slot) begin
			link_fresh_q <= 1'b0;
		end
	end

	// Data store
	always_ff @(posedge clk) begin
		if (ctl.rd_slot) begin
			data_rd_q <= data_mem[head_slot];
		end
		if (ctl.wr_push) begin
			data_mem[free_slot] <= val_q;
		end
	end

	// Free list head and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			hwm_q       <= '0;
		end else begin
			if (ctl.wr_push) begin
				free_head_q <= link_cur;
				if (link_fresh_q) begin
					hwm_q <= hwm_q + LINK_W'(1);
				end
			end else if (ctl.wr_pop) begin
				free_head_q <= head_cur;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status_q <= ctl.out_code;
			out_pop_q    <= ctl.wr_pop ? data_rd_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign pop_value = out_pop_q;

endmodule

`default_nettype wire

// File: design/multi_stack_shared_buffer.sv
// Several LIFO stacks sharing one slot pool: each word pushes push_value onto, or pops
// from, the stack named by stack_id, and gives back exactly one result word with status
// (done, refused full, refused empty) and pop_value (zero unless a pop succeeded). One
// word is worked at a time. A push or a refused pop holds the block for the accept
// cycle, then write back and result load. A successful pop adds a slot-read step between
// these, since its head read and the dependent slot read each go through a synchronous
// memory read port. The result word is loaded into the output register in the word's last
// state; a stalled result holds the block in that state until the output register frees,
// while the input side waits. The link store needs no clearing pass after reset: a fill
// count stands in for its initial chain, so the first word is taken right away.
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_buffer import mssb_pkg::*; #(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int CAPACITY   = CAPACITY_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// request word
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       cmd,
	input  wire logic [SID_IN_W-1:0]        stack_id,
	input  wire logic signed [VALUE_W-1:0]  push_value,
	// result word
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [STATUS_W-1:0]             status,
	output logic signed [VALUE_W-1:0]       pop_value
);

	mssb_cmd_t ctl;
	mssb_sts_t sts;

	// Sequence each word: capture and first reads, then write back and report.
	mssb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	// Hold the stores, the free list and the result register.
	mssb_datapath #(
		.NUM_STACKS (NUM_STACKS),
		.CAPACITY   (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.stack_id   (stack_id),
		.push_value (push_value),
		.out_stall  (out_stall),
		.ctl        (ctl),
		.sts        (sts),
		.out_valid  (out_valid),
		.status     (status),
		.pop_value  (pop_value)
	);

endmodule

`default_nettype wire

// File: design/mssb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "multi_stack_shared_buffer_defines.svh"

module mssb_checker import mssb_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [STATUS_W-1:0]        status,
	input wire logic signed [VALUE_W-1:0]  pop_value
);

	// Hold a stalled result word.
	`MSSB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(pop_value), "result word changed while stalled")

	// Only a successful pop carries data.
	`MSSB_ASSERT_SAME(a_pop_zero, out_valid && (status != ST_DONE), pop_value == '0, "refused word carries nonzero pop_value")

	// One word at a time: stall right after an accept.
	`MSSB_ASSERT_NEXT(a_one_word, in_valid && !in_stall, in_stall, "request accepted while another word is in work")

endmodule

bind multi_stack_shared_buffer mssb_checker u_mssb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.pop_value (pop_value)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mssb_pkg::*;

	localparam int SLOTS = CAPACITY_DEF;
	localparam int STACKS = NUM_STACKS_DEF;
	localparam logic [6:0] NO_SLOT = 7'(SLOTS);
	localparam int OP_COUNT = 700;

	// One request word and one result word, at the port widths.
	typedef struct packed {
		logic                         op;
		logic [SID_IN_W-1:0]          sid;
		logic signed [VALUE_W-1:0]    val;
	} request_t;

	typedef struct packed {
		status_t                      code;
		logic signed [VALUE_W-1:0]    val;
	} result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         cmd = CMD_PUSH;
	logic [SID_IN_W-1:0]          stack_id = '0;
	logic signed [VALUE_W-1:0]    push_value = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [STATUS_W-1:0]          status;
	logic signed [VALUE_W-1:0]    pop_value;

	multi_stack_shared_buffer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.stack_id   (stack_id),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.pop_value  (pop_value)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hold reset, then release it away from the rising edge.
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow of the shared slot pool: data per slot, a link per slot, one
	// head link per stack and the head of the free chain. A link equal to
	// the slot count means "none".
	// ------------------------------------------------------------------
	logic signed [VALUE_W-1:0] slot_data [SLOTS];
	logic [6:0]                slot_link [SLOTS];
	logic [6:0]                top_slot  [STACKS];
	logic [6:0]                free_slot;

	request_t todo_ops[$];       // words still to be sent
	result_t  owed_results[$];   // results the block still owes, oldest first

	int err_count = 0;
	int in_gap = 0, in_quiet = 0, out_hold = 0, out_quiet = 0;

	// Occupancy as seen by the generator, used only to steer the stimulus.
	int gen_depth [STACKS];
	int gen_used = 0;

	function automatic void clear_stacks();
		for (int i = 0; i < SLOTS; i++) begin
			slot_data[i] = '0;
			slot_link[i] = 7'(i + 1);
		end
		for (int s = 0; s < STACKS; s++) begin
			top_slot[s] = NO_SLOT;
			gen_depth[s] = 0;
		end
		free_slot = '0;
	endfunction

	// Any link past the pool counts as "none".
	function automatic logic [6:0] sane_link(logic [6:0] l);
		return (l < NO_SLOT) ? l : NO_SLOT;
	endfunction

	// Apply one word to the shadow pool and return the result it must produce.
	function automatic result_t apply_stack_op(request_t rq);
		result_t    r;
		logic [6:0] slot;
		r.code = ST_DONE;
		r.val = '0;
		if (rq.op == CMD_PUSH) begin
			slot = free_slot;
			if (int'(rq.sid) >= STACKS || slot >= NO_SLOT) begin
				r.code = ST_FULL;
			end else begin
				free_slot = sane_link(slot_link[slot]);
				slot_data[slot] = rq.val;
				slot_link[slot] = top_slot[rq.sid];
				top_slot[rq.sid] = slot;
			end
		end else if (int'(rq.sid) >= STACKS) begin
			r.code = ST_EMPTY;
		end else begin
			slot = top_slot[rq.sid];
			if (slot >= NO_SLOT) begin
				r.code = ST_EMPTY;
			end else begin
				// unlink the head, hand its slot back to the front of the free chain
				top_slot[rq.sid] = sane_link(slot_link[slot]);
				r.val = slot_data[slot];
				slot_link[slot] = free_slot;
				free_slot = slot;
			end
		end
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Datum with the extremes mixed in.
	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Queue one word and track the coarse occupancy it leads to.
	task automatic add_op(logic op, int sid, logic signed [VALUE_W-1:0] v);
		request_t rq;
		rq.op = op;
		rq.sid = SID_IN_W'(sid);
		rq.val = v;
		if (op == CMD_PUSH) begin
			if (gen_used < SLOTS) begin
				gen_used++;
				gen_depth[sid]++;
			end
		end else if (gen_depth[sid] > 0) begin
			gen_depth[sid]--;
			gen_used--;
		end
		todo_ops.push_back(rq);
	endtask

	// ------------------------------------------------------------------
	// Stimulus: a directed opening, then phases that fill, drain or mix.
	// ------------------------------------------------------------------
	initial begin
		int phase_len, push_pct, hot_a, hot_b, sid, kind;
		logic op;
		bit first;

		clear_stacks();

		// empty pops on both end stacks, with a live datum on the pop word
		add_op(CMD_POP, 0, 32'sh1234_5678);
		add_op(CMD_POP, 7, '1);
		// extreme data on the end stacks and on a middle one
		add_op(CMD_PUSH, 0, 32'sh7FFF_FFFF);
		add_op(CMD_PUSH, 7, 32'sh8000_0000);
		add_op(CMD_PUSH, 3, '1);
		add_op(CMD_PUSH, 3, '0);
		// last in comes out first, then the stack runs dry
		add_op(CMD_POP, 3, 32'sh5555_5555);
		add_op(CMD_POP, 3, '0);
		add_op(CMD_POP, 3, '0);
		add_op(CMD_POP, 7, '0);
		add_op(CMD_POP, 0, '0);
		// alternating bit patterns through one stack
		add_op(CMD_PUSH, 5, 32'sh5555_5555);
		add_op(CMD_PUSH, 5, 32'shAAAA_AAAA);
		add_op(CMD_POP, 5, '0);
		add_op(CMD_POP, 5, '0);
		add_op(CMD_POP, 5, '0);

		// Start with a fill long enough to hit "store full", then random phases.
		first = 1'b1;
		while (todo_ops.size() < OP_COUNT) begin
			kind = first ? 0 : $urandom_range(0, 2);
			phase_len = first ? 90 : $urandom_range(40, 120);
			first = 1'b0;
			push_pct = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
			hot_a = $urandom_range(0, STACKS - 1);
			hot_b = $urandom_range(0, STACKS - 1);
			repeat (phase_len) begin
				op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
				if (op == CMD_POP && gen_used > 0 && $urandom_range(0, 99) < 85) begin
					// aim most pops at a stack that holds something
					do
						sid = $urandom_range(0, STACKS - 1);
					while (gen_depth[sid] == 0);
				end else if ($urandom_range(0, 1) == 0) begin
					sid = $urandom_range(0, 1) ? hot_a : hot_b;
				end else begin
					sid = $urandom_range(0, STACKS - 1);
				end
				add_op(op, sid, pick_word());
			end
		end

		@(posedge arst_n);
		// Drain: every word sent, every owed result seen. Look between edges,
		// once the driver and the monitor have settled.
		while (todo_ops.size() != 0 || in_valid || owed_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request driver: present words from todo_ops, predict on acceptance,
	// insert random gaps with occasional stretches of back-to-back words.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		request_t nxt;
		request_t seen;
		logic     load;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_PUSH;
			stack_id <= '0;
			push_value <= '0;
			in_gap = 0;
			in_quiet = 0;
		end else begin
			load = !in_valid;
			if (in_valid && !in_stall) begin
				seen.op = cmd;
				seen.sid = stack_id;
				seen.val = push_value;
				owed_results.push_back(apply_stack_op(seen));
				load = 1'b1;
				if (in_quiet > 0) begin
					in_quiet--;
				end else begin
					in_gap = idle_len();
					if ($urandom_range(0, 39) == 0)
						in_quiet = $urandom_range(20, 60);
				end
			end
			// a stalled word stays put; otherwise idle or advance
			if (load) begin
				if (in_gap > 0 || todo_ops.size() == 0) begin
					in_valid <= 1'b0;
					if (in_gap > 0)
						in_gap--;
				end else begin
					nxt = todo_ops.pop_front();
					in_valid <= 1'b1;
					cmd <= nxt.op;
					stack_id <= nxt.sid;
					push_value <= nxt.val;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: check each accepted result word against the oldest
	// owed result, and throttle the output with random stall stretches.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold = 0;
			out_quiet = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result word, status %0d pop_value %0d",
						$time, status, pop_value);
					err_count++;
				end else begin
					want = owed_results.pop_front();
					if (status !== want.code) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.code, status);
						err_count++;
					end
					if (pop_value !== want.val) begin
						$display("%0t: pop_value expected %0d got %0d",
							$time, want.val, pop_value);
						err_count++;
					end
				end
			end
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
				if (out_quiet > 0) begin
					out_quiet--;
				end else begin
					out_hold = idle_len();
					if ($urandom_range(0, 39) == 0)
						out_quiet = $urandom_range(20, 60);
				end
			end
		end
	end

endmodule
